// ===== design/cpfv_pkg.sv =====
package cpfv_pkg;

	// Input and digit geometry.
	localparam int ID_W      = 37;
	localparam int DIGITS    = 11;
	localparam int BCD_W     = 4 * DIGITS;
	localparam logic [ID_W-1:0] ID_MAX = 37'd99999999999;

	// Double-dabble conversion is spread over five stages.
	localparam int DAB_STEPS = 8;
	localparam int DAB_LAST  = ID_W - 4 * DAB_STEPS;

	// Widest weighted sums: 9 * (10 + ... + 2) and 9 * (11 + ... + 2).
	localparam int SUM1_W = 9;
	localparam int SUM2_W = 10;

	// Stream byte padding.
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	typedef logic [3:0]       digit_t;
	typedef logic [BCD_W-1:0] bcd_t;
	typedef logic [ID_W-1:0]  id_t;

	// Weighted sums and the two check digits, passed from the sum stage on.
	typedef struct packed {
		logic [SUM1_W-1:0] sum1;
		logic [SUM2_W-1:0] sum2;
		digit_t            dig9;
		digit_t            dig10;
	} sums_t;

	// Digit i counted from the most significant end (d0) of the BCD word.
	function automatic digit_t bcd_digit(bcd_t bcd, int idx);
		return bcd[4 * (DIGITS - 1 - idx) +: 4];
	endfunction

	// Expected check digit for a weighted sum s: (s * 10) mod 11, where a
	// remainder of ten becomes zero. Since 10 = -1 and 32 = -1 (mod 11),
	// the value is folded as lo - hi before a short compare-subtract chain.
	function automatic digit_t check_digit(logic [SUM2_W-1:0] s);
		logic [4:0] lo;
		logic [4:0] hi;
		logic [5:0] t;
		logic [3:0] m;
		logic [3:0] r;
		lo = s[4:0];
		hi = 5'(s >> 5);
		t  = 6'(lo) + 6'd22 - 6'(hi);
		if (t >= 6'd44) begin
			m = 4'(t - 6'd44);
		end else if (t >= 6'd33) begin
			m = 4'(t - 6'd33);
		end else if (t >= 6'd22) begin
			m = 4'(t - 6'd22);
		end else if (t >= 6'd11) begin
			m = 4'(t - 6'd11);
		end else begin
			m = t[3:0];
		end
		r = (m == 4'd0) ? 4'd0 : 4'd11 - m;
		if (r == 4'd10) begin
			r = 4'd0;
		end
		return r;
	endfunction

endpackage

// ===== design/cpf_check_digit_validator.sv =====
// Mod-11 check-digit validator for eleven-digit identity numbers. Each
// transaction on the slave stream carries one number as a binary integer;
// the master stream returns one bit per number, 1 when both check digits
// match and 0 otherwise (also 0 for any value above 99999999999). The block
// keeps no state between numbers and takes one number per clock cycle while
// the master side is ready. Each number passes through five stages of binary
// to BCD conversion, one stage for the weighted sums and one for the mod-11
// checks, whose register is the output register. Results leave in input order;
// a stall on the master side holds the pipeline and fills its empty stages.
module cpf_check_digit_validator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [cpfv_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [36:0] id_number
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [cpfv_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [0] valid_res
);
	import cpfv_pkg::*;

	// Valid bits of the seven stages.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	// Payload registers.
	bcd_t  bcd_s1, bcd_s2, bcd_s3, bcd_s4, bcd_s5;
	id_t   bin_s1, bin_s2, bin_s3, bin_s4;
	logic  rng_s1, rng_s2, rng_s3, rng_s4, rng_s5, rng_s6;
	sums_t sums_s6;
	logic  res_s7;

	// Stage logic outputs.
	id_t   id_in;
	bcd_t  bcd_n1, bcd_n2, bcd_n3, bcd_n4, bcd_n5;
	id_t   bin_n1, bin_n2, bin_n3, bin_n4, bin_n5;
	sums_t sums_n6;
	logic  res_n7;

	assign id_in = s_axis_tdata[ID_W-1:0];

	// A stage may load when it is empty or its content moves on.
	assign rdy7 = !vld_s7 || m_axis_tready;
	assign rdy6 = !vld_s6 || rdy7;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign s_axis_tready = rdy1;

	cpfv_dabble #(.STEPS(DAB_STEPS)) u_dab1 (
		.bcd_in('0), .bin_in(id_in), .bcd_out(bcd_n1), .bin_out(bin_n1)
	);
	cpfv_dabble #(.STEPS(DAB_STEPS)) u_dab2 (
		.bcd_in(bcd_s1), .bin_in(bin_s1), .bcd_out(bcd_n2), .bin_out(bin_n2)
	);
	cpfv_dabble #(.STEPS(DAB_STEPS)) u_dab3 (
		.bcd_in(bcd_s2), .bin_in(bin_s2), .bcd_out(bcd_n3), .bin_out(bin_n3)
	);
	cpfv_dabble #(.STEPS(DAB_STEPS)) u_dab4 (
		.bcd_in(bcd_s3), .bin_in(bin_s3), .bcd_out(bcd_n4), .bin_out(bin_n4)
	);
	cpfv_dabble #(.STEPS(DAB_LAST)) u_dab5 (
		.bcd_in(bcd_s4), .bin_in(bin_s4), .bcd_out(bcd_n5), .bin_out(bin_n5)
	);

	cpfv_sum u_sum (
		.bcd(bcd_s5), .sums(sums_n6)
	);

	cpfv_check u_check (
		.sums(sums_s6), .in_range(rng_s6), .valid_res(res_n7)
	);

	// Valid bits advance with the ready chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_axis_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
			if (rdy7) vld_s7 <= vld_s6;
		end
	end

	// Payload loads only when a valid item moves into the stage.
	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			bcd_s1 <= bcd_n1;
			bin_s1 <= bin_n1;
			rng_s1 <= (id_in <= ID_MAX);
		end
		if (rdy2 && vld_s1) begin
			bcd_s2 <= bcd_n2;
			bin_s2 <= bin_n2;
			rng_s2 <= rng_s1;
		end
		if (rdy3 && vld_s2) begin
			bcd_s3 <= bcd_n3;
			bin_s3 <= bin_n3;
			rng_s3 <= rng_s2;
		end
		if (rdy4 && vld_s3) begin
			bcd_s4 <= bcd_n4;
			bin_s4 <= bin_n4;
			rng_s4 <= rng_s3;
		end
		if (rdy5 && vld_s4) begin
			bcd_s5 <= bcd_n5;
			rng_s5 <= rng_s4;
		end
		if (rdy6 && vld_s5) begin
			sums_s6 <= sums_n6;
			rng_s6  <= rng_s5;
		end
		if (rdy7 && vld_s6) begin
			res_s7 <= res_n7;
		end
	end

	assign m_axis_tvalid = vld_s7;
	assign m_axis_tdata  = {(M_TDATA_W - 1)'(0), res_s7};

	// Every digit of a finished conversion is a decimal digit.
	logic bcd_ok_s5;
	always_comb begin
		bcd_ok_s5 = 1'b1;
		for (int j = 0; j < DIGITS; j++) begin
			if (bcd_s5[4 * j +: 4] > 4'd9) begin
				bcd_ok_s5 = 1'b0;
			end
		end
	end

	// The unused bits of the final binary word are all shifted out.
	logic bin_done;
	assign bin_done = (bin_n5 == '0);

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while the output register is empty");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s1)
		else $error("accepted transaction did not reach the first stage");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !rdy4 |=> vld_s3 && $stable(bcd_s3) && $stable(bin_s3))
		else $error("stalled conversion stage lost or changed its item");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && rng_s5 |-> bcd_ok_s5 && bin_done)
		else $error("conversion produced a non-decimal digit");

endmodule

// ===== design/cpfv_dabble.sv =====
// One slice of the binary to BCD conversion: a fixed number of shift-add-3
// steps, each taking the next most significant bit of the binary word.
module cpfv_dabble #(
	parameter int STEPS = cpfv_pkg::DAB_STEPS
) (
	input  cpfv_pkg::bcd_t bcd_in,
	input  cpfv_pkg::id_t  bin_in,
	output cpfv_pkg::bcd_t bcd_out,
	output cpfv_pkg::id_t  bin_out
);
	import cpfv_pkg::*;

	always_comb begin
		bcd_t bcd;
		id_t  bin;
		bcd = bcd_in;
		bin = bin_in;
		for (int k = 0; k < STEPS; k++) begin
			// Bias every digit of five or more so the shift carries correctly.
			for (int j = 0; j < DIGITS; j++) begin
				if (bcd[4 * j +: 4] >= 4'd5) begin
					bcd[4 * j +: 4] = bcd[4 * j +: 4] + 4'd3;
				end
			end
			bcd = {bcd[BCD_W-2:0], bin[ID_W-1]};
			bin = {bin[ID_W-2:0], 1'b0};
		end
		bcd_out = bcd;
		bin_out = bin;
	end

endmodule

// ===== design/cpfv_sum.sv =====
// Weighted digit sums for both check digits.
module cpfv_sum (
	input  cpfv_pkg::bcd_t  bcd,
	output cpfv_pkg::sums_t sums
);
	import cpfv_pkg::*;

	always_comb begin
		logic [SUM1_W-1:0] acc1;
		logic [SUM2_W-1:0] acc2;
		acc1 = '0;
		acc2 = '0;
		// First sum over d0..d8 with weights 10 down to 2.
		for (int i = 0; i < DIGITS - 2; i++) begin
			acc1 = acc1 + SUM1_W'(bcd_digit(bcd, i)) * SUM1_W'(10 - i);
		end
		// Second sum over d0..d9 with weights 11 down to 2.
		for (int i = 0; i < DIGITS - 1; i++) begin
			acc2 = acc2 + SUM2_W'(bcd_digit(bcd, i)) * SUM2_W'(11 - i);
		end
		sums.sum1  = acc1;
		sums.sum2  = acc2;
		sums.dig9  = bcd_digit(bcd, DIGITS - 2);
		sums.dig10 = bcd_digit(bcd, DIGITS - 1);
	end

endmodule

// ===== design/cpfv_check.sv =====
// Final verdict: both check digits match and the number fits in eleven digits.
module cpfv_check (
	input  cpfv_pkg::sums_t sums,
	input  logic            in_range,
	output logic            valid_res
);
	import cpfv_pkg::*;

	digit_t exp1;
	digit_t exp2;

	always_comb begin
		exp1      = check_digit(SUM2_W'(sums.sum1));
		exp2      = check_digit(sums.sum2);
		valid_res = in_range && (exp1 == sums.dig9) && (exp2 == sums.dig10);
	end

endmodule

// ===== tb/tb_cpf_check_digit_validator.sv =====
`timescale 1ns / 1ps

module tb_cpf_check_digit_validator;
	import cpfv_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int DRAIN_CYCLES   = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_AT    = 400;
	localparam int HOLD_OFF_LEN   = 300;
	localparam int DIR_N          = 18;

	// One row of the directed table: the number, and a typed answer where one is given.
	typedef struct packed {
		id_t  id;
		logic typed;
		logic answer;
	} dir_row_t;

	localparam id_t ALL_ONES = '1;

	localparam dir_row_t DIRECTED [DIR_N] = '{
		'{id_t'(0),            1'b1, 1'b1},  // all zeros, both sums are zero
		'{ID_MAX,              1'b0, 1'b0},  // largest eleven-digit number
		'{ID_MAX + 37'd1,      1'b1, 1'b0},  // first value with twelve digits
		'{ALL_ONES,            1'b1, 1'b0},  // widest input
		'{id_t'(37'd68719476736), 1'b0, 1'b0},  // top bit alone
		'{id_t'(37'd52998224725), 1'b0, 1'b0},  // a well-formed number
		'{id_t'(37'd52998224726), 1'b0, 1'b0},  // second check digit off by one
		'{id_t'(37'd52998224735), 1'b0, 1'b0},  // first check digit off by one
		'{id_t'(37'd604),      1'b0, 1'b0},  // first remainder is ten, digit is zero
		'{id_t'(37'd614),      1'b0, 1'b0},  // same prefix with a one in place of the zero
		'{id_t'(37'd11111111111), 1'b0, 1'b0},  // repeated digits
		'{id_t'(37'd55555555555), 1'b0, 1'b0},
		'{id_t'(37'd99999999998), 1'b0, 1'b0},
		'{id_t'(37'd1),        1'b0, 1'b0},
		'{id_t'(37'd10),       1'b0, 1'b0},
		'{id_t'(37'h15_5555_5555), 1'b0, 1'b0},  // alternating bit patterns
		'{id_t'(37'h0A_AAAA_AAAA), 1'b0, 1'b0},
		'{id_t'(37'd12345678909), 1'b0, 1'b0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	// Expected valid bits, oldest first.
	logic expected_valid [$];

	int  errors = 0;
	int  numbers_sent = 0;
	int  results_seen = 0;
	int  valid_seen = 0;
	int  input_stall_cycles = 0;
	int  idle_cycles = 0;
	bit  calm = 1'b0;

	cpf_check_digit_validator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Mod-11 check digit over the first count digits of a BCD word, weights count+1 down to 2.
	function automatic digit_t mod11_check(bcd_t bcd, int count);
		int unsigned sum;
		int unsigned rem;
		sum = 0;
		for (int i = 0; i < count; i++) begin
			sum += 32'(bcd[4 * (DIGITS - 1 - i) +: 4]) * (count + 1 - i);
		end
		rem = (sum * 10) % 11;
		if (rem == 10) begin
			rem = 0;
		end
		return digit_t'(rem);
	endfunction

	// Predicts the valid bit for one number.
	function automatic logic cpf_is_valid(id_t id);
		longint unsigned v;
		bcd_t bcd;
		v = 64'(id);
		if (v > longint'(ID_MAX)) begin
			return 1'b0;
		end
		for (int i = 0; i < DIGITS; i++) begin
			bcd[4 * i +: 4] = digit_t'(v % 10);
			v = v / 10;
		end
		return (mod11_check(bcd, 9) == bcd[4 +: 4]) && (mod11_check(bcd, 10) == bcd[0 +: 4]);
	endfunction

	// Builds a well-formed number with random digits, optionally with one digit changed.
	function automatic id_t make_cpf(bit damage);
		bcd_t bcd;
		longint unsigned v;
		int pos;
		for (int i = 0; i < 9; i++) begin
			bcd[4 * (DIGITS - 1 - i) +: 4] = digit_t'($urandom_range(0, 9));
		end
		bcd[4 +: 4] = mod11_check(bcd, 9);
		bcd[0 +: 4] = mod11_check(bcd, 10);
		if (damage) begin
			pos = $urandom_range(0, DIGITS - 1);
			bcd[4 * pos +: 4] =
				digit_t'((32'(bcd[4 * pos +: 4]) + $urandom_range(1, 9)) % 10);
		end
		v = 0;
		for (int i = DIGITS - 1; i >= 0; i--) begin
			v = v * 10 + 64'(bcd[4 * i +: 4]);
		end
		return id_t'(v);
	endfunction

	// Random number for the open part: mostly built numbers, well-formed or with one digit changed, the rest noise.
	function automatic id_t random_id();
		int unsigned pick;
		longint unsigned raw;
		longint unsigned span;
		pick = $urandom_range(0, 99);
		raw = {$urandom, $urandom};
		span = (longint'(1) << ID_W) - longint'(ID_MAX) - 1;
		if (pick < 45) begin
			return make_cpf(1'b0);
		end else if (pick < 75) begin
			return make_cpf(1'b1);
		end else if (pick < 90) begin
			return id_t'(raw % (longint'(ID_MAX) + 1));
		end else if (pick < 95) begin
			return id_t'(longint'(ID_MAX) + 1 + raw % span);
		end
		return id_t'(raw);
	endfunction

	// Gap length: mostly short, a few long.
	function automatic int gap_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return $urandom_range(1, 3);
		end else if (pick < 95) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	// Offers one number and waits until the block takes it.
	task automatic send_number(id_t id, logic answer);
		int gap;
		gap = (!calm && $urandom_range(0, 2) == 0) ? gap_length() : 0;
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= S_TDATA_W'(id);
		do @(posedge clk); while (!s_axis_tready);
		expected_valid.push_back(answer);
		numbers_sent++;
	endtask

	// Receiver: random stalls, plus one long hold-off while input keeps coming.
	initial begin
		int hold;
		bit hold_off_done;
		hold = 0;
		hold_off_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
				hold_off_done = 1'b1;
				hold = HOLD_OFF_LEN;
			end else if (hold == 0 && !calm && $urandom_range(0, 7) == 0) begin
				hold = gap_length();
			end
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest expected bit.
	always @(posedge clk) begin
		logic want;
		if (arst_n && s_axis_tvalid && !s_axis_tready) begin
			input_stall_cycles++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			valid_seen += int'(m_axis_tdata[0]);
			if (expected_valid.size() == 0) begin
				$display("%0t: unexpected result, actual valid_res=%0b", $time, m_axis_tdata[0]);
				errors++;
			end else begin
				want = expected_valid.pop_front();
				if (m_axis_tdata[0] !== want) begin
					$display("%0t: valid_res mismatch, expected %0b actual %0b",
						$time, want, m_axis_tdata[0]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		id_t id;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed table: typed answers where obvious, the predictor elsewhere.
		for (int i = 0; i < DIR_N; i++) begin
			send_number(DIRECTED[i].id,
				DIRECTED[i].typed ? DIRECTED[i].answer : cpf_is_valid(DIRECTED[i].id));
		end

		// Random part, with calm stretches where neither side adds random gaps.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			id = random_id();
			send_number(id, cpf_is_valid(id));
		end
		calm = 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (expected_valid.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d numbers (%0d from the directed table); %0d results, %0d valid.",
			numbers_sent, DIR_N, results_seen, valid_seen);
		$display("Output held off %0d cycles in one stretch; input stalled for %0d cycles.",
			HOLD_OFF_LEN, input_stall_cycles);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
